// File: src/can_bit_timing_solver_macros.svh
// ----------------------------------------------------------------------------
// CAN bit timing solver assertion macros
// Assertion wrappers shared by the solver RTL; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef CAN_BIT_TIMING_SOLVER_MACROS_SVH
`define CAN_BIT_TIMING_SOLVER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define CBTS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define CBTS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CBTS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define CBTS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: src/cbts_pkg.sv
// ----------------------------------------------------------------------------
// CAN bit timing solver package
// Shared widths, constants, controller types and segment split functions.
// ----------------------------------------------------------------------------
package cbts_pkg;

  // Field and datapath widths
  localparam int KBPS_W    = 10;
  localparam int PRESC_W   = 10;
  localparam int SEG1_W    = 5;
  localparam int SEG2_W    = 3;
  localparam int SJW_W     = 3;
  localparam int CLK_W     = 32;
  localparam int RATE_W    = 20;
  localparam int NUM_W     = CLK_W + 1;
  localparam int TQ_ARG_W  = 7;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Default parameter values
  localparam int DEF_MAX_PRESCALER = 512;
  localparam int DEF_MAX_QUANTA    = 25;

  // Fixed constants of the timing calculation
  localparam int MIN_QUANTA      = 8;
  localparam int FALLBACK_QUANTA = 10;
  localparam int SJW_LIMIT       = 4;
  localparam int HZ_PER_KHZ      = 1000;

  // Register reset values
  localparam logic [CLK_W-1:0]  RESET_CLOCK_HZ     = 32'd85000000;
  localparam logic [KBPS_W-1:0] RESET_DEFAULT_KBPS = 10'd500;

  // Register word indexes
  localparam logic REG_CLOCK_HZ     = 1'b0;
  localparam logic REG_DEFAULT_KBPS = 1'b1;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATE,
    ST_DEN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FB_DEN,
    ST_FB_GO,
    ST_FB_WAIT,
    ST_DONE
  } ctrl_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic mul_rate;
    logic mul_den;
    logic use_fb;
    logic tq_inc;
    logic div_go;
    logic keep_hit;
    logic keep_fb;
    logic keep_zero;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic rate_zero;
    logic div_busy;
    logic div_done;
    logic div_match;
    logic tq_last;
  } stat_t;

  // Segment two: a quarter of the quanta after the sync quantum, at least one.
  function automatic logic [SEG2_W-1:0] seg2_of(input logic [TQ_ARG_W-1:0] tq);
    logic [TQ_ARG_W-1:0] b;
    b = (tq - TQ_ARG_W'(1)) >> 2;
    if (b == '0) begin
      b = TQ_ARG_W'(1);
    end
    return b[SEG2_W-1:0];
  endfunction

  // Segment one: the remaining quanta after sync and segment two.
  function automatic logic [SEG1_W-1:0] seg1_of(input logic [TQ_ARG_W-1:0] tq);
    logic [TQ_ARG_W-1:0] b;
    logic [TQ_ARG_W-1:0] s1;
    b = (tq - TQ_ARG_W'(1)) >> 2;
    if (b == '0) begin
      b = TQ_ARG_W'(1);
    end
    s1 = tq - TQ_ARG_W'(1) - b;
    return s1[SEG1_W-1:0];
  endfunction

  // Jump width: segment two, limited to four quanta.
  function automatic logic [SJW_W-1:0] sjw_of(input logic [TQ_ARG_W-1:0] tq);
    logic [TQ_ARG_W-1:0] b;
    b = (tq - TQ_ARG_W'(1)) >> 2;
    if (b == '0) begin
      b = TQ_ARG_W'(1);
    end
    if (b >= TQ_ARG_W'(SJW_LIMIT)) begin
      b = TQ_ARG_W'(SJW_LIMIT);
    end
    return b[SJW_W-1:0];
  endfunction

endpackage

// File: src/cbts_div.sv
// ----------------------------------------------------------------------------
// CAN bit timing solver divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbts_div #(
  parameter int NUM_W = cbts_pkg::NUM_W,
  parameter int DEN_W = cbts_pkg::RATE_W + 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] dv_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    trial   = {rem_r, num_r[NUM_W-1]};
    diff    = trial - {1'b0, dv_r};
    ge      = (trial >= {1'b0, dv_r});
    rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      rem_r <= '0;
      dv_r  <= den;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = num_r;
  assign rem  = rem_r;

endmodule

// File: src/cbts_dp.sv
// ----------------------------------------------------------------------------
// CAN bit timing solver datapath
// Rate and divisor products, divider, candidate test and result registers.
// ----------------------------------------------------------------------------
module cbts_dp #(
  parameter int MAX_PRESCALER = cbts_pkg::DEF_MAX_PRESCALER,
  parameter int MAX_QUANTA    = cbts_pkg::DEF_MAX_QUANTA
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cbts_pkg::cmd_t                cmd,
  output cbts_pkg::stat_t               stat,
  input  logic [cbts_pkg::KBPS_W-1:0]   in_kbps,
  input  logic [cbts_pkg::CLK_W-1:0]    clock_hz,
  input  logic [cbts_pkg::KBPS_W-1:0]   default_kbps,
  output logic [cbts_pkg::PRESC_W-1:0]  res_prescaler,
  output logic [cbts_pkg::SEG1_W-1:0]   res_seg1,
  output logic [cbts_pkg::SEG2_W-1:0]   res_seg2,
  output logic [cbts_pkg::SJW_W-1:0]    res_jump_width,
  output logic                          res_exact
);

  localparam int TQ_W  = $clog2(MAX_QUANTA + 1);
  localparam int DEN_W = cbts_pkg::RATE_W + TQ_W;
  localparam int NUM_W = cbts_pkg::NUM_W;
  localparam int PW    = cbts_pkg::PRESC_W;

  localparam logic [cbts_pkg::RATE_W-1:0] KHZ = cbts_pkg::RATE_W'(cbts_pkg::HZ_PER_KHZ);
  localparam logic [TQ_W-1:0]  TQ_MIN   = TQ_W'(cbts_pkg::MIN_QUANTA);
  localparam logic [TQ_W-1:0]  TQ_FB    = TQ_W'(cbts_pkg::FALLBACK_QUANTA);
  localparam logic [TQ_W-1:0]  TQ_MAX   = TQ_W'(MAX_QUANTA);
  localparam logic [NUM_W-1:0] PMAX_Q   = NUM_W'(MAX_PRESCALER);
  localparam logic [PW-1:0]    PMAX_FLD = PW'(MAX_PRESCALER);

  logic [cbts_pkg::KBPS_W-1:0] kbps_r;
  logic [cbts_pkg::RATE_W-1:0] rate_r;
  logic [TQ_W-1:0]             tq_r;
  logic [DEN_W-1:0]            den_r;
  logic [PW-1:0]               keep_presc_r;
  logic [TQ_W-1:0]             keep_tq_r;
  logic                        keep_exact_r;
  logic [PW-1:0]               out_presc_r;
  logic [cbts_pkg::SEG1_W-1:0] out_seg1_r;
  logic [cbts_pkg::SEG2_W-1:0] out_seg2_r;
  logic [cbts_pkg::SJW_W-1:0]  out_sjw_r;
  logic                        out_exact_r;

  logic [TQ_W-1:0]  mul_tq;
  logic [NUM_W-1:0] div_num;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic             div_busy;
  logic             div_done;
  logic [PW-1:0]    fb_presc;
  logic [cbts_pkg::TQ_ARG_W-1:0] keep_tq_ext;

  // Operand selection for the divisor product and the dividend.
  always_comb begin
    mul_tq  = cmd.use_fb ? TQ_FB : tq_r;
    div_num = {1'b0, clock_hz};
    if (cmd.use_fb) begin
      div_num = {1'b0, clock_hz} + NUM_W'(den_r >> 1);
    end
  end

  // Rounded fallback prescaler, clamped to the legal range.
  always_comb begin
    if (quo == '0) begin
      fb_presc = PW'(1);
    end else if (quo > PMAX_Q) begin
      fb_presc = PMAX_FLD;
    end else begin
      fb_presc = quo[PW-1:0];
    end
  end

  // Request capture, rate product, quanta counter and divisor product.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kbps_r <= (in_kbps == '0) ? default_kbps : in_kbps;
    end
    if (cmd.mul_rate) begin
      rate_r <= cbts_pkg::RATE_W'(kbps_r) * KHZ;
    end
    if (cmd.capture) begin
      tq_r <= TQ_MIN;
    end else if (cmd.tq_inc) begin
      tq_r <= tq_r + TQ_W'(1);
    end
    if (cmd.mul_den) begin
      den_r <= DEN_W'(rate_r) * DEN_W'(mul_tq);
    end
  end

  // Divider shared by the exact search and the fallback.
  cbts_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_go),
    .num   (div_num),
    .den   (den_r),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (quo),
    .rem   (rem)
  );

  // Chosen timing, held until the output register is free.
  always_ff @(posedge clk) begin
    if (cmd.keep_hit) begin
      keep_presc_r <= quo[PW-1:0];
      keep_tq_r    <= tq_r;
      keep_exact_r <= 1'b1;
    end else if (cmd.keep_fb) begin
      keep_presc_r <= fb_presc;
      keep_tq_r    <= TQ_FB;
      keep_exact_r <= 1'b0;
    end else if (cmd.keep_zero) begin
      // Zero rate: only a zero clock divides exactly, at the first pair.
      if (clock_hz == '0) begin
        keep_presc_r <= PW'(1);
        keep_tq_r    <= TQ_MIN;
        keep_exact_r <= 1'b1;
      end else begin
        keep_presc_r <= PMAX_FLD;
        keep_tq_r    <= TQ_FB;
        keep_exact_r <= 1'b0;
      end
    end
  end

  assign keep_tq_ext = cbts_pkg::TQ_ARG_W'(keep_tq_r);

  // Output payload register with the segment split.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_presc_r <= keep_presc_r;
      out_seg1_r  <= cbts_pkg::seg1_of(keep_tq_ext);
      out_seg2_r  <= cbts_pkg::seg2_of(keep_tq_ext);
      out_sjw_r   <= cbts_pkg::sjw_of(keep_tq_ext);
      out_exact_r <= keep_exact_r;
    end
  end

  // Status back to the controller.
  always_comb begin
    stat.rate_zero = (rate_r == '0);
    stat.div_busy  = div_busy;
    stat.div_done  = div_done;
    stat.div_match = (rem == '0) && (quo != '0) && (quo <= PMAX_Q);
    stat.tq_last   = (tq_r == TQ_MAX);
  end

  assign res_prescaler  = out_presc_r;
  assign res_seg1       = out_seg1_r;
  assign res_seg2       = out_seg2_r;
  assign res_jump_width = out_sjw_r;
  assign res_exact      = out_exact_r;

endmodule

// File: src/cbts_ctrl.sv
// ----------------------------------------------------------------------------
// CAN bit timing solver controller
// Sequences the quanta search, the fallback and the result handshake.
// ----------------------------------------------------------------------------
module cbts_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  cbts_pkg::stat_t stat,
  output cbts_pkg::cmd_t  cmd
);

  cbts_pkg::ctrl_state_t state_r;
  cbts_pkg::ctrl_state_t state_nxt;
  logic                  out_valid_r;
  logic                  out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == cbts_pkg::ST_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cbts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Result valid flag: set on load, cleared when the result is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      cbts_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = cbts_pkg::ST_RATE;
        end
      end
      cbts_pkg::ST_RATE: begin
        cmd.mul_rate = 1'b1;
        state_nxt    = cbts_pkg::ST_DEN;
      end
      cbts_pkg::ST_DEN: begin
        if (stat.rate_zero) begin
          cmd.keep_zero = 1'b1;
          state_nxt     = cbts_pkg::ST_DONE;
        end else begin
          cmd.mul_den = 1'b1;
          state_nxt   = cbts_pkg::ST_DIV_GO;
        end
      end
      cbts_pkg::ST_DIV_GO: begin
        cmd.div_go = 1'b1;
        state_nxt  = cbts_pkg::ST_DIV_WAIT;
      end
      cbts_pkg::ST_DIV_WAIT: begin
        if (stat.div_done) begin
          if (stat.div_match) begin
            cmd.keep_hit = 1'b1;
            state_nxt    = cbts_pkg::ST_DONE;
          end else if (stat.tq_last) begin
            state_nxt = cbts_pkg::ST_FB_DEN;
          end else begin
            cmd.tq_inc = 1'b1;
            state_nxt  = cbts_pkg::ST_DEN;
          end
        end
      end
      cbts_pkg::ST_FB_DEN: begin
        cmd.mul_den = 1'b1;
        cmd.use_fb  = 1'b1;
        state_nxt   = cbts_pkg::ST_FB_GO;
      end
      cbts_pkg::ST_FB_GO: begin
        cmd.div_go = 1'b1;
        cmd.use_fb = 1'b1;
        state_nxt  = cbts_pkg::ST_FB_WAIT;
      end
      cbts_pkg::ST_FB_WAIT: begin
        if (stat.div_done) begin
          cmd.keep_fb = 1'b1;
          state_nxt   = cbts_pkg::ST_DONE;
        end
      end
      cbts_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = cbts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cbts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/can_bit_timing_solver.sv
// ----------------------------------------------------------------------------
// CAN bit timing solver
// Derives nominal CAN prescaler and segments from the kernel clock.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Contents
//  in_       slave      tvalid/tready           kbps request
//  out_      master     tvalid/tready           prescaler, segments, exact flag
//  cfg_      APB slave  psel/penable/pready     clock_hz, default_kbps
//
// Each quanta candidate costs a divisor product, a divider start and a
// bit-serial division. Candidates rise from the minimum quanta; the first
// exact hit ends the search, else the rounded fallback is taken after the
// last candidate, and a zero rate skips the search.
// Reset is synchronous; registers return to 85 MHz and 500 kbit/s.
// A finished result waits in the output register while the next request
// is accepted; the solver stalls only if that result is still pending.
// ----------------------------------------------------------------------------
`include "can_bit_timing_solver_macros.svh"

module can_bit_timing_solver #(
  parameter int MAX_PRESCALER = cbts_pkg::DEF_MAX_PRESCALER,
  parameter int MAX_QUANTA    = cbts_pkg::DEF_MAX_QUANTA
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [15:0]                       in_tdata,    // [9:0] kbps
  // Result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [23:0]                       out_tdata,   // [9:0] prescaler,
                                                         // [14:10] seg1,
                                                         // [17:15] seg2,
                                                         // [20:18] jump_width
  output logic                              out_tuser,   // [0] exact
  // Configuration port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [cbts_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [cbts_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [cbts_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  logic [cbts_pkg::CLK_W-1:0]   clock_hz_r;
  logic [cbts_pkg::KBPS_W-1:0]  default_kbps_r;
  logic                         cfg_wr;
  logic                         reg_sel;

  cbts_pkg::cmd_t               cmd;
  cbts_pkg::stat_t              stat;
  logic [cbts_pkg::PRESC_W-1:0] res_prescaler;
  logic [cbts_pkg::SEG1_W-1:0]  res_seg1;
  logic [cbts_pkg::SEG2_W-1:0]  res_seg2;
  logic [cbts_pkg::SJW_W-1:0]   res_jump_width;
  logic                         res_exact;

  // Configuration registers, one word each.
  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r     <= cbts_pkg::RESET_CLOCK_HZ;
      default_kbps_r <= cbts_pkg::RESET_DEFAULT_KBPS;
    end else if (cfg_wr) begin
      case (reg_sel)
        cbts_pkg::REG_CLOCK_HZ:     clock_hz_r     <= cfg_pwdata;
        cbts_pkg::REG_DEFAULT_KBPS: default_kbps_r <= cfg_pwdata[cbts_pkg::KBPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_sel)
      cbts_pkg::REG_CLOCK_HZ:     cfg_prdata = clock_hz_r;
      cbts_pkg::REG_DEFAULT_KBPS: cfg_prdata = cbts_pkg::CFG_DATA_W'(default_kbps_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  // Sequencer.
  cbts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Arithmetic and result registers.
  cbts_dp #(
    .MAX_PRESCALER (MAX_PRESCALER),
    .MAX_QUANTA    (MAX_QUANTA)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_kbps        (in_tdata[cbts_pkg::KBPS_W-1:0]),
    .clock_hz       (clock_hz_r),
    .default_kbps   (default_kbps_r),
    .res_prescaler  (res_prescaler),
    .res_seg1       (res_seg1),
    .res_seg2       (res_seg2),
    .res_jump_width (res_jump_width),
    .res_exact      (res_exact)
  );

  // Result packing.
  assign out_tdata = {3'b000, res_jump_width, res_seg2, res_seg1, res_prescaler};
  assign out_tuser = res_exact;

  // Checks on the sequencing.
  `CBTS_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.load_out, !out_tvalid || out_tready, "result overwritten while pending")
  `CBTS_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready, "second request taken during a solve")
  `CBTS_ASSERT_IMP(a_div_idle_start, clk, rst_n, cmd.div_go, !stat.div_busy, "divider restarted while busy")

endmodule
